>>> hw/rtl/lkt_pkg.sv
// shared types and constants for the link key table
package lkt_pkg;

    localparam int ADDR_W              = 48;
    localparam int HALF_KEY_W          = 64;
    localparam int KEY_W               = 2 * HALF_KEY_W;
    localparam int LKT_ENTRIES_DEFAULT = 8;
    localparam logic [ADDR_W-1:0] EMPTY_ADDR = '0;

    // command codes carried in the opcode field
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } lkt_op_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC,
        ST_RESP
    } lkt_state_t;

    // strobes from controller to datapath
    typedef struct packed {
        logic capture;
        logic match;
        logic exec;
        logic resp_load;
    } lkt_ctrl_t;

endpackage

>>> hw/rtl/lkt_cmd_if.sv
// command channel: one table operation per item
interface lkt_cmd_if;
    import lkt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [ADDR_W-1:0]     device_address;
    logic [HALF_KEY_W-1:0] key_upper;
    logic [HALF_KEY_W-1:0] key_lower;

    modport source (output valid, opcode, device_address, key_upper, key_lower,
                    input ready);
    modport sink   (input valid, opcode, device_address, key_upper, key_lower,
                    output ready);
endinterface

>>> hw/rtl/lkt_rsp_if.sv
// response channel: one result per command
interface lkt_rsp_if;
    import lkt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  success;
    logic [HALF_KEY_W-1:0] found_key_upper;
    logic [HALF_KEY_W-1:0] found_key_lower;

    modport source (output valid, success, found_key_upper, found_key_lower,
                    input ready);
    modport sink   (input valid, success, found_key_upper, found_key_lower,
                    output ready);
endinterface

>>> hw/rtl/link_key_table_unit.sv
// top level of the link key table
//
//  channel  dir  handshake     payload
//  cmd      in   valid/ready   opcode, device_address, key_upper, key_lower
//  rsp      out  valid/ready   success, found_key_upper, found_key_lower
//
// each command steps through accept, compare all slots, execute on the
// lowest matching slot (an add with no match uses the lowest empty one,
// a clear all slots) and load the result register. a result stalled on rsp
// holds the controller before its next result load, not the next accept.
// reset clears all slot addresses and key valid bits at once, no sweep.
module link_key_table_unit #(
    parameter int TABLE_ENTRIES = lkt_pkg::LKT_ENTRIES_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    lkt_cmd_if.sink   cmd,
    lkt_rsp_if.source rsp
);
    import lkt_pkg::*;

    lkt_ctrl_t ctrl;

    // sequencer
    lkt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    // table and result path
    lkt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .opcode          (cmd.opcode),
        .device_address  (cmd.device_address),
        .key_upper       (cmd.key_upper),
        .key_lower       (cmd.key_lower),
        .success         (rsp.success),
        .found_key_upper (rsp.found_key_upper),
        .found_key_lower (rsp.found_key_lower)
    );

endmodule

>>> hw/rtl/lkt_ctrl.sv
// sequencing state machine for the link key table
module lkt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output lkt_pkg::lkt_ctrl_t ctrl
);
    import lkt_pkg::*;

    lkt_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // state and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and strobes
    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        cmd_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                ctrl.match = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // wait until the output register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    ctrl.resp_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule

>>> hw/rtl/lkt_datapath.sv
// slot registers, key memory, match logic and result register
module lkt_datapath #(
    parameter int TABLE_ENTRIES = lkt_pkg::LKT_ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lkt_pkg::lkt_ctrl_t             ctrl,
    input  logic [1:0]                     opcode,
    input  logic [lkt_pkg::ADDR_W-1:0]     device_address,
    input  logic [lkt_pkg::HALF_KEY_W-1:0] key_upper,
    input  logic [lkt_pkg::HALF_KEY_W-1:0] key_lower,
    output logic                           success,
    output logic [lkt_pkg::HALF_KEY_W-1:0] found_key_upper,
    output logic [lkt_pkg::HALF_KEY_W-1:0] found_key_lower
);
    import lkt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // captured command
    lkt_op_t             op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [KEY_W-1:0]    key_reg;

    // table storage
    logic [ADDR_W-1:0]        slot_addr_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] key_valid_reg;
    logic [KEY_W-1:0]         key_mem [TABLE_ENTRIES];

    // match vectors
    logic [TABLE_ENTRIES-1:0] hit_vec_reg;
    logic [TABLE_ENTRIES-1:0] empty_vec_reg;

    // execute results
    logic             ok_reg;
    logic             get_reg;
    logic             rd_valid_reg;
    logic [KEY_W-1:0] rd_key_reg;

    // result register
    logic                  rsp_success_reg;
    logic [KEY_W-1:0]      rsp_key_reg;

    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] empty_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             hit_any;
    logic             empty_any;
    logic             ok;
    logic             add_fill;
    logic             key_write;

    // capture the command item
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            op_reg   <= lkt_op_t'(opcode);
            addr_reg <= device_address;
            key_reg  <= {key_upper, key_lower};
        end
    end

    // parallel compare against every slot
    always_ff @(posedge clk)
    begin
        if (ctrl.match)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                hit_vec_reg[i]   <= (slot_addr_reg[i] == addr_reg);
                empty_vec_reg[i] <= (slot_addr_reg[i] == EMPTY_ADDR);
            end
        end
    end

    // lowest set bit of each match vector
    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (empty_vec_reg[i])
            begin
                empty_idx = IDX_W'(i);
            end
        end
    end

    assign hit_any   = |hit_vec_reg;
    assign empty_any = |empty_vec_reg;
    assign add_fill  = (op_reg == OP_ADD) && !hit_any && empty_any;
    assign wr_idx    = hit_any ? hit_idx : empty_idx;
    assign key_write = ctrl.exec && (op_reg == OP_ADD) && (hit_any || empty_any);

    // success flag per operation
    always_comb
    begin
        case (op_reg) inside
            OP_ADD:             ok = hit_any || empty_any;
            OP_GET, OP_REMOVE:  ok = hit_any;
            default:            ok = 1'b1;
        endcase
    end

    // key memory: one read per execute cycle, plus a write on an add that finds a slot
    always_ff @(posedge clk)
    begin
        if (key_write)
        begin
            key_mem[wr_idx] <= key_reg;
        end
        if (ctrl.exec)
        begin
            rd_key_reg   <= key_mem[hit_idx];
            rd_valid_reg <= key_valid_reg[hit_idx];
            ok_reg       <= ok;
            get_reg      <= (op_reg == OP_GET);
        end
    end

    // slot addresses and key valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_addr_reg[i] <= EMPTY_ADDR;
            end
            key_valid_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            if (op_reg == OP_CLEAR)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    slot_addr_reg[i] <= EMPTY_ADDR;
                end
                key_valid_reg <= '0;
            end
            else
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (add_fill && (IDX_W'(i) == empty_idx))
                    begin
                        slot_addr_reg[i] <= addr_reg;
                    end
                    if ((op_reg == OP_REMOVE) && hit_any && (IDX_W'(i) == hit_idx))
                    begin
                        slot_addr_reg[i] <= EMPTY_ADDR;
                        key_valid_reg[i] <= 1'b0;
                    end
                    if (key_write && (IDX_W'(i) == wr_idx))
                    begin
                        key_valid_reg[i] <= 1'b1;
                    end
                end
            end
        end
    end

    // result register, key shown only on a successful get
    always_ff @(posedge clk)
    begin
        if (ctrl.resp_load)
        begin
            rsp_success_reg <= ok_reg;
            rsp_key_reg     <= (ok_reg && get_reg && rd_valid_reg) ? rd_key_reg : '0;
        end
    end

    assign success         = rsp_success_reg;
    assign found_key_upper = rsp_key_reg[KEY_W-1:HALF_KEY_W];
    assign found_key_lower = rsp_key_reg[HALF_KEY_W-1:0];

endmodule

>>> hw/rtl/lkt_checker.sv
// port-level checks for the link key table, bound to the top level
module lkt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic                           rsp_success,
    input logic [lkt_pkg::HALF_KEY_W-1:0] found_key_upper,
    input logic [lkt_pkg::HALF_KEY_W-1:0] found_key_lower
);
    import lkt_pkg::*;

    logic cmd_accept;

    assign cmd_accept = cmd_valid && cmd_ready;

    // a waiting result is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // busy through the match, execute and first result-load state
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> !cmd_ready ##1 !cmd_ready ##1 !cmd_ready)
        else $error("new item taken while a command is in flight");

    // a result is on offer once the command has passed match, execute and result load
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |-> ##4 rsp_valid)
        else $error("no result after command");

    // a failed command never returns key bits
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_success |-> (found_key_upper == '0) && (found_key_lower == '0))
        else $error("key bits on a failed result");

endmodule

bind link_key_table_unit lkt_checker u_lkt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_success     (rsp.success),
    .found_key_upper (rsp.found_key_upper),
    .found_key_lower (rsp.found_key_lower)
);
